### hw/rtl/spd_pkg.sv
// shared types and constants for the segment pair distance block
// used by spd_dist_unit and segment_pair_distance; no dependencies
package spd_pkg;

	localparam int DIST_W      = 26;
	localparam int QUOT_W      = DIST_W + 1;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_W       = 16;

	localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
	localparam logic [CFG_W-1:0]  TOL_RESET = 16'd1;

	typedef enum logic [1:0] {
		ORI_COLIN,
		ORI_CW,
		ORI_CCW
	} orient_t;

endpackage

### hw/rtl/segment_pair_distance.sv
// top level: shortest distance between two 2-d segments, one pair per cycle unless m_tready stalls
// orientation test and pass setup here, root and divide in spd_dist_unit
// depends on spd_pkg and spd_dist_unit
//
//  channel   signals                         content
//  s_        s_tvalid s_tready s_tdata       a_start_x .. b_end_y, COORD_WIDTH each
//  m_        m_tvalid m_tready m_tdata       seg_distance; m_tuser intersects
//  cfg_      cfg_valid cfg_ready cfg_data    colinear_tolerance
//
// one item per cycle unless m_tready stalls; the pipeline runs through the
// one-bit-per-stage square root and the one-bit-per-stage divider
// arst_n clears all valid bits and sets the tolerance to 1
// a stall on m_tready freezes every stage at once; s_tready follows it
module segment_pair_distance import spd_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// seg_distance
	output logic [OUT_TDATA_W-1:0]                 m_tdata,
	// intersects
	output logic                                   m_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_W-1:0]                       cfg_data
);

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;
	localparam int PW  = 2*CW + 2;
	localparam int SW  = 2*CW + 3;
	localparam int RW  = 2*CW + 2;
	localparam int CMW = 2*CW + 2;
	localparam int UL  = (CW + 1) + 1 + QUOT_W;

	logic en;
	logic [CFG_W-1:0] tol_q;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// stage 1: input capture
	logic                 vld_s1;
	logic signed [CW-1:0] c_s1 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	for (genvar f = 0; f < 8; f++) begin : g_in
		always_ff @(posedge clk) begin
			if (en) begin
				c_s1[f] <= s_tdata[f*CW +: CW];
			end
		end
	end

	// stages 2..5 valid bits
	logic vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// orientation test: p, q, r points per cross product, bbox checks alongside
	logic signed [DW-1:0] od_s2 [4][4];
	logic                 win_s2 [4];
	logic                 win_s3 [4];
	logic                 win_s4 [4];
	logic signed [PW-1:0] om_s3 [4][2];
	logic signed [SW-1:0] ov_s4 [4];
	orient_t              ori [4];

	for (genvar k = 0; k < 4; k++) begin : g_ori
		localparam int P = (k < 2) ? 0 : 4;
		localparam int Q = P + 2;
		localparam int R = (k < 2) ? 4 + 2*k : 2*(k-2);
		logic signed [CW-1:0] xlo, xhi, ylo, yhi;
		logic signed [SW-1:0] omag;

		assign xlo = (c_s1[P] < c_s1[Q]) ? c_s1[P] : c_s1[Q];
		assign xhi = (c_s1[P] < c_s1[Q]) ? c_s1[Q] : c_s1[P];
		assign ylo = (c_s1[P+1] < c_s1[Q+1]) ? c_s1[P+1] : c_s1[Q+1];
		assign yhi = (c_s1[P+1] < c_s1[Q+1]) ? c_s1[Q+1] : c_s1[P+1];

		always_ff @(posedge clk) begin
			if (en) begin
				od_s2[k][0] <= DW'(c_s1[Q+1]) - DW'(c_s1[P+1]);
				od_s2[k][1] <= DW'(c_s1[R])   - DW'(c_s1[Q]);
				od_s2[k][2] <= DW'(c_s1[Q])   - DW'(c_s1[P]);
				od_s2[k][3] <= DW'(c_s1[R+1]) - DW'(c_s1[Q+1]);
				win_s2[k]   <= c_s1[R] >= xlo && c_s1[R] <= xhi &&
				               c_s1[R+1] >= ylo && c_s1[R+1] <= yhi;
				om_s3[k][0] <= PW'(od_s2[k][0]) * PW'(od_s2[k][1]);
				om_s3[k][1] <= PW'(od_s2[k][2]) * PW'(od_s2[k][3]);
				win_s3[k]   <= win_s2[k];
				ov_s4[k]    <= SW'(om_s3[k][0]) - SW'(om_s3[k][1]);
				win_s4[k]   <= win_s3[k];
			end
		end

		assign omag = (ov_s4[k] < 0) ? -ov_s4[k] : ov_s4[k];

		always_comb begin
			if (omag <= SW'(tol_q)) begin
				ori[k] = ORI_COLIN;
			end else if (ov_s4[k] > 0) begin
				ori[k] = ORI_CW;
			end else begin
				ori[k] = ORI_CCW;
			end
		end
	end

	logic crosses;
	logic isect_s5;

	assign crosses = (ori[0] != ori[1] && ori[2] != ori[3]) ||
	                 (ori[0] == ORI_COLIN && win_s4[0]) ||
	                 (ori[1] == ORI_COLIN && win_s4[1]) ||
	                 (ori[2] == ORI_COLIN && win_s4[2]) ||
	                 (ori[3] == ORI_COLIN && win_s4[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			isect_s5 <= crosses;
		end
	end

	// distance passes: pass 0 measures a against b, pass 1 b against a
	logic [DIST_W-1:0] pdist [2];

	for (genvar p = 0; p < 2; p++) begin : g_pass
		localparam int RB = (p == 0) ? 4 : 0;
		localparam int OB = (p == 0) ? 0 : 4;

		logic signed [CW-1:0] sx, sy, ex, ey, px, py, qx, qy;
		// dx dy osx osy oex oey fx fy
		logic signed [DW-1:0] d_s2 [8];
		// dxdx dydy sxdx sydy exdx eydy eydx exdy sydx sxdy sxsx sysy exex eyey fxfx fyfy
		logic signed [PW-1:0] m_s3 [16];
		logic [RW-1:0]        l2_s4, ns_s4, ne_s4, nf_s4;
		logic signed [SW-1:0] d1_s4, d2_s4, cre_s4, crs_s4;
		logic signed [SW-1:0] crsel;
		logic [RW-1:0]        rad_s5;
		logic [CMW-1:0]       crm_s5;
		logic                 perp_s5;

		// order both segments by x, equal x keeps the given order
		always_comb begin
			if (c_s1[RB] > c_s1[RB+2]) begin
				sx = c_s1[RB+2]; sy = c_s1[RB+3]; ex = c_s1[RB]; ey = c_s1[RB+1];
			end else begin
				sx = c_s1[RB]; sy = c_s1[RB+1]; ex = c_s1[RB+2]; ey = c_s1[RB+3];
			end
			if (c_s1[OB] > c_s1[OB+2]) begin
				px = c_s1[OB+2]; py = c_s1[OB+3]; qx = c_s1[OB]; qy = c_s1[OB+1];
			end else begin
				px = c_s1[OB]; py = c_s1[OB+1]; qx = c_s1[OB+2]; qy = c_s1[OB+3];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s2[0] <= DW'(ex) - DW'(sx);
				d_s2[1] <= DW'(ey) - DW'(sy);
				d_s2[2] <= DW'(px) - DW'(sx);
				d_s2[3] <= DW'(py) - DW'(sy);
				d_s2[4] <= DW'(qx) - DW'(sx);
				d_s2[5] <= DW'(qy) - DW'(sy);
				d_s2[6] <= DW'(px) - DW'(ex);
				d_s2[7] <= DW'(py) - DW'(ey);

				m_s3[0]  <= PW'(d_s2[0]) * PW'(d_s2[0]);
				m_s3[1]  <= PW'(d_s2[1]) * PW'(d_s2[1]);
				m_s3[2]  <= PW'(d_s2[2]) * PW'(d_s2[0]);
				m_s3[3]  <= PW'(d_s2[3]) * PW'(d_s2[1]);
				m_s3[4]  <= PW'(d_s2[4]) * PW'(d_s2[0]);
				m_s3[5]  <= PW'(d_s2[5]) * PW'(d_s2[1]);
				m_s3[6]  <= PW'(d_s2[5]) * PW'(d_s2[0]);
				m_s3[7]  <= PW'(d_s2[4]) * PW'(d_s2[1]);
				m_s3[8]  <= PW'(d_s2[3]) * PW'(d_s2[0]);
				m_s3[9]  <= PW'(d_s2[2]) * PW'(d_s2[1]);
				m_s3[10] <= PW'(d_s2[2]) * PW'(d_s2[2]);
				m_s3[11] <= PW'(d_s2[3]) * PW'(d_s2[3]);
				m_s3[12] <= PW'(d_s2[4]) * PW'(d_s2[4]);
				m_s3[13] <= PW'(d_s2[5]) * PW'(d_s2[5]);
				m_s3[14] <= PW'(d_s2[6]) * PW'(d_s2[6]);
				m_s3[15] <= PW'(d_s2[7]) * PW'(d_s2[7]);

				// squares are never negative, so their bits add as unsigned
				l2_s4  <= unsigned'(m_s3[0])  + unsigned'(m_s3[1]);
				ns_s4  <= unsigned'(m_s3[10]) + unsigned'(m_s3[11]);
				ne_s4  <= unsigned'(m_s3[12]) + unsigned'(m_s3[13]);
				nf_s4  <= unsigned'(m_s3[14]) + unsigned'(m_s3[15]);
				d1_s4  <= SW'(m_s3[2]) + SW'(m_s3[3]);
				d2_s4  <= SW'(m_s3[4]) + SW'(m_s3[5]);
				cre_s4 <= SW'(m_s3[6]) - SW'(m_s3[7]);
				crs_s4 <= SW'(m_s3[8]) - SW'(m_s3[9]);
			end
		end

		assign crsel = (d1_s4 < 0) ? cre_s4 : crs_s4;

		always_ff @(posedge clk) begin
			if (en) begin
				crm_s5 <= (crsel < 0) ? CMW'(-crsel) : CMW'(crsel);
				if (l2_s4 == '0) begin
					rad_s5  <= ns_s4;
					perp_s5 <= 1'b0;
				end else if (d2_s4 < 0) begin
					rad_s5  <= ne_s4;
					perp_s5 <= 1'b0;
				end else if (d1_s4 > $signed({1'b0, l2_s4})) begin
					rad_s5  <= nf_s4;
					perp_s5 <= 1'b0;
				end else begin
					rad_s5  <= l2_s4;
					perp_s5 <= 1'b1;
				end
			end
		end

		spd_dist_unit #(
			.CW(CW)
		) u_dist (
			.clk      (clk),
			.en       (en),
			.rad      (rad_s5),
			.perp     (perp_s5),
			.crmag    (crm_s5),
			.dist_len (pdist[p])
		);
	end

	// valid and flag ride along with the root and divide stages
	logic tail_vld_s [UL+1];
	logic tail_isc_s [UL+1];

	assign tail_vld_s[0] = vld_s5;
	assign tail_isc_s[0] = isect_s5;

	for (genvar t = 0; t < UL; t++) begin : g_tail
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tail_vld_s[t+1] <= 1'b0;
			end else if (en) begin
				tail_vld_s[t+1] <= tail_vld_s[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tail_isc_s[t+1] <= tail_isc_s[t];
			end
		end
	end

	// output register
	logic              out_vld_sn;
	logic [DIST_W-1:0] out_dist_sn;
	logic              out_isc_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_sn <= 1'b0;
		end else if (en) begin
			out_vld_sn <= tail_vld_s[UL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_isc_sn <= tail_isc_s[UL];
			if (tail_isc_s[UL]) begin
				out_dist_sn <= '0;
			end else begin
				out_dist_sn <= (pdist[0] < pdist[1]) ? pdist[0] : pdist[1];
			end
		end
	end

	assign m_tvalid = out_vld_sn;
	assign m_tdata  = OUT_TDATA_W'(out_dist_sn);
	assign m_tuser  = out_isc_sn;

endmodule

### hw/rtl/spd_dist_unit.sv
// square root then restoring divide, one bit per stage, for one distance pass
// yields an endpoint length or |cross| / length, saturated to the output width
// depends on spd_pkg
module spd_dist_unit import spd_pkg::*; #(
	parameter int CW = 24
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*CW+1:0]     rad,
	input  logic                perp,
	input  logic [2*CW+1:0]     crmag,
	output logic [DIST_W-1:0]   dist_len
);

	localparam int RW  = 2*CW + 2;
	localparam int SQ  = CW + 1;
	localparam int CMW = 2*CW + 2;
	localparam int XW  = ((CMW > SQ + QUOT_W) ? CMW : SQ + QUOT_W) + 1;
	localparam int GW  = (SQ > QUOT_W) ? SQ : QUOT_W;

	// square root stages
	logic [RW-1:0]  rt_n_s [SQ+1];
	logic [RW-1:0]  rt_r_s [SQ+1];
	logic           rt_p_s [SQ+1];
	logic [CMW-1:0] rt_c_s [SQ+1];

	assign rt_n_s[0] = rad;
	assign rt_r_s[0] = '0;
	assign rt_p_s[0] = perp;
	assign rt_c_s[0] = crmag;

	for (genvar i = 0; i < SQ; i++) begin : g_root
		logic [RW:0] bitv;
		logic [RW:0] trial;
		logic        take;

		assign bitv  = (RW+1)'(1) << (2*(SQ-1-i));
		assign trial = {1'b0, rt_r_s[i]} + bitv;
		assign take  = {1'b0, rt_n_s[i]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_n_s[i+1] <= take ? rt_n_s[i] - trial[RW-1:0] : rt_n_s[i];
				rt_r_s[i+1] <= take ? (rt_r_s[i] >> 1) + bitv[RW-1:0]
				                    : (rt_r_s[i] >> 1);
				rt_p_s[i+1] <= rt_p_s[i];
				rt_c_s[i+1] <= rt_c_s[i];
			end
		end
	end

	// divide stages, stage 0 is the overflow check
	logic [XW-1:0]     dv_rem_s [QUOT_W+1];
	logic [SQ-1:0]     dv_div_s [QUOT_W+1];
	logic [QUOT_W-1:0] dv_q_s   [QUOT_W+1];
	logic              dv_p_s   [QUOT_W+1];
	logic              dv_ovf_s [QUOT_W+1];

	logic [SQ-1:0] root;
	assign root = rt_r_s[SQ][SQ-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= XW'(rt_c_s[SQ]);
			dv_div_s[0] <= root;
			dv_q_s[0]   <= '0;
			dv_p_s[0]   <= rt_p_s[SQ];
			dv_ovf_s[0] <= XW'(rt_c_s[SQ]) >= (XW'(root) << QUOT_W);
		end
	end

	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		logic [XW-1:0] sh;
		logic          take;

		assign sh   = XW'(dv_div_s[k]) << (QUOT_W-1-k);
		assign take = dv_rem_s[k] >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k+1] <= take ? dv_rem_s[k] - sh : dv_rem_s[k];
				dv_q_s[k+1]   <= take ? dv_q_s[k] | (QUOT_W'(1) << (QUOT_W-1-k))
				                      : dv_q_s[k];
				dv_div_s[k+1] <= dv_div_s[k];
				dv_p_s[k+1]   <= dv_p_s[k];
				dv_ovf_s[k+1] <= dv_ovf_s[k];
			end
		end
	end

	logic [GW-1:0] raw;

	always_comb begin
		if (!dv_p_s[QUOT_W]) begin
			raw = GW'(dv_div_s[QUOT_W]);
		end else if (dv_ovf_s[QUOT_W]) begin
			raw = GW'(DIST_MAX);
		end else begin
			raw = GW'(dv_q_s[QUOT_W]);
		end
		dist_len = (raw > GW'(DIST_MAX)) ? DIST_MAX : raw[DIST_W-1:0];
	end

endmodule

### test/segment_pair_distance_test.sv
// testbench for segment_pair_distance: a scoreboard predicts distance and flag per pair
// depends on spd_pkg and segment_pair_distance; no other files
`timescale 1ns / 1ps

class distance_scoreboard;
	typedef struct {
		logic [spd_pkg::DIST_W-1:0] seg_dist;
		logic                        hit;
	} dist_result_t;

	dist_result_t expected_q[$];
	logic [spd_pkg::CFG_W-1:0] tolerance;
	int errors;
	int checked;
	int hits;

	function new();
		tolerance = spd_pkg::TOL_RESET;
		errors = 0;
		checked = 0;
		hits = 0;
	endfunction

	static function longint unsigned abs64(longint x);
		return x < 0 ? -x : x;
	endfunction

	static function longint unsigned root64(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	static function longint unsigned hypot64(longint x, longint y);
		return root64(abs64(x) * abs64(x) + abs64(y) * abs64(y));
	endfunction

	function spd_pkg::orient_t turn(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (abs64(v) <= longint'(tolerance))
			return spd_pkg::ORI_COLIN;
		return v > 0 ? spd_pkg::ORI_CW : spd_pkg::ORI_CCW;
	endfunction

	static function bit on_box(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint xl, xh, yl, yh;
		xl = px < rx ? px : rx;
		xh = px < rx ? rx : px;
		yl = py < ry ? py : ry;
		yh = py < ry ? ry : py;
		return qx >= xl && qx <= xh && qy >= yl && qy <= yh;
	endfunction

	function bit segments_touch(longint a[4], longint b[4]);
		spd_pkg::orient_t o1, o2, o3, o4;
		o1 = turn(a[0], a[1], a[2], a[3], b[0], b[1]);
		o2 = turn(a[0], a[1], a[2], a[3], b[2], b[3]);
		o3 = turn(b[0], b[1], b[2], b[3], a[0], a[1]);
		o4 = turn(b[0], b[1], b[2], b[3], a[2], a[3]);
		if (o1 != o2 && o3 != o4) return 1;
		if (o1 == spd_pkg::ORI_COLIN && on_box(a[0], a[1], b[0], b[1], a[2], a[3])) return 1;
		if (o2 == spd_pkg::ORI_COLIN && on_box(a[0], a[1], b[2], b[3], a[2], a[3])) return 1;
		if (o3 == spd_pkg::ORI_COLIN && on_box(b[0], b[1], a[0], a[1], b[2], b[3])) return 1;
		if (o4 == spd_pkg::ORI_COLIN && on_box(b[0], b[1], a[2], a[3], b[2], b[3])) return 1;
		return 0;
	endfunction

	// distance of segment o measured against reference segment r
	static function longint unsigned ref_pass(longint r[4], longint o[4]);
		longint sx, sy, ex, ey, px, py, qx, qy, t, dx, dy, osx, osy, oex, oey, d1, d2, cr;
		longint unsigned l2;
		sx = r[0]; sy = r[1]; ex = r[2]; ey = r[3];
		px = o[0]; py = o[1]; qx = o[2]; qy = o[3];
		if (sx > ex) begin
			t = sx; sx = ex; ex = t; t = sy; sy = ey; ey = t;
		end
		if (px > qx) begin
			t = px; px = qx; qx = t; t = py; py = qy; qy = t;
		end
		dx = ex - sx;
		dy = ey - sy;
		osx = px - sx; osy = py - sy;
		oex = qx - sx; oey = qy - sy;
		l2 = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy);
		if (l2 == 0)
			return hypot64(osx, osy);
		d1 = osx * dx + osy * dy;
		d2 = oex * dx + oey * dy;
		if (d2 < 0)
			return hypot64(oex, oey);
		if (d1 > 0 && longint'(d1) > longint'(l2))
			return hypot64(px - ex, py - ey);
		if (d1 < 0)
			cr = oey * dx - oex * dy;
		else
			cr = osy * dx - osx * dy;
		return abs64(cr) / root64(l2);
	endfunction

	function void note_pair(logic [191:0] data);
		longint a[4], b[4];
		longint unsigned p1, p2, d;
		dist_result_t res;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(data[24*i +: 24]));
			b[i] = longint'($signed(data[24*(i+4) +: 24]));
		end
		if (segments_touch(a, b)) begin
			res.seg_dist = '0;
			res.hit = 1'b1;
		end else begin
			p1 = ref_pass(b, a);
			p2 = ref_pass(a, b);
			d = p1 < p2 ? p1 : p2;
			res.seg_dist = d > longint'(spd_pkg::DIST_MAX) ? spd_pkg::DIST_MAX : d[25:0];
			res.hit = 1'b0;
		end
		expected_q.push_back(res);
	endfunction

	function void check_result(logic [31:0] data, logic flag);
		dist_result_t res;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result dist=%0d flag=%0b", $time, data, flag);
			errors++;
			return;
		end
		res = expected_q.pop_front();
		checked++;
		if (res.hit) hits++;
		if (data !== {6'd0, res.seg_dist}) begin
			$display("%0t: seg_distance expected %0d actual %0d", $time, res.seg_dist, data);
			errors++;
		end
		if (flag !== res.hit) begin
			$display("%0t: intersects expected %0b actual %0b", $time, res.hit, flag);
			errors++;
		end
	endfunction
endclass

module segment_pair_distance_test;
	import spd_pkg::*;

	logic clk = 0;
	logic arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser, cfg_valid, cfg_ready;
	logic [191:0] s_tdata;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [CFG_W-1:0] cfg_data;

	distance_scoreboard sb = new();
	bit quiet;
	bit hold_req;
	int idle_cycles;
	int pairs_sent;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	segment_pair_distance dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			m_tready <= quiet || $urandom_range(99) >= 6;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int coord(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [191:0] random_pair();
		int c[8];
		int r, span;
		r = $urandom_range(99);
		span = r < 45 ? 64 : (r < 60 ? 4096 : 8388607);
		for (int i = 0; i < 8; i++)
			c[i] = span == 8388607 ? int'($signed(24'($urandom))) : coord(span);
		r = $urandom_range(9);
		if (r == 0) begin
			c[2] = c[0]; c[3] = c[1];
		end else if (r == 1) begin
			c[6] = c[4]; c[7] = c[5];
		end else if (r == 2) begin
			c[4] = c[2]; c[5] = c[3];
		end else if (r == 3) begin
			c[6] = c[4];
		end
		return {24'(c[7]), 24'(c[6]), 24'(c[5]), 24'(c[4]),
			24'(c[3]), 24'(c[2]), 24'(c[1]), 24'(c[0])};
	endfunction

	task automatic send_pair(logic [191:0] data);
		if (!quiet && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_pair(data);
		pairs_sent++;
	endtask

	task automatic write_tolerance(logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.tolerance = value;
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_pair(random_pair());
	endtask

	localparam int PMAX = 8388607;
	localparam int PMIN = -8388608;

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at reset tolerance
		send_pair({8{24'h7fffff}});
		send_pair({8{24'h800000}});
		send_pair({24'(PMIN), 24'(PMAX), 24'(PMAX), 24'(PMIN),
			24'(PMAX), 24'(PMAX), 24'(PMIN), 24'(PMIN)});
		send_pair({24'(PMAX), 24'(PMAX), 24'(PMAX), 24'(PMIN),
			24'(PMIN), 24'(PMAX), 24'(PMIN), 24'(PMIN)});
		send_pair({24'(0), 24'(256), 24'(256), 24'(0), 24'(256), 24'(256), 24'(0), 24'(0)});
		// shared endpoint
		send_pair({24'(512), 24'(512), 24'(0), 24'(256), 24'(0), 24'(256), 24'(0), 24'(0)});
		// collinear overlap and collinear disjoint
		send_pair({24'(0), 24'(768), 24'(0), 24'(256), 24'(0), 24'(512), 24'(0), 24'(0)});
		send_pair({24'(0), 24'(768), 24'(0), 24'(512), 24'(0), 24'(256), 24'(0), 24'(0)});
		// parallel
		send_pair({24'(256), 24'(512), 24'(256), 24'(0), 24'(0), 24'(512), 24'(0), 24'(0)});
		// both zero length, then zero-length b
		send_pair({-24'(40), 24'(300), -24'(40), 24'(300), 24'(10), 24'(10), 24'(10), 24'(10)});
		send_pair({24'(300), 24'(256), 24'(300), 24'(256), 24'(0), 24'(512), 24'(0), 24'(0)});
		// vertical segments, equal x
		send_pair({24'(0), 24'(256), 24'(512), 24'(256), 24'(512), 24'(0), 24'(0), 24'(0)});
		// endpoints given right to left
		send_pair({24'(400), -24'(50), 24'(300), 24'(600), 24'(100), 24'(0), 24'(0), 24'(512)});
		// beyond end and before start of the reference
		send_pair({24'(90), 24'(400), 24'(50), 24'(300), 24'(0), 24'(100), 24'(0), 24'(0)});
		send_pair({24'(80), -24'(200), 24'(50), -24'(300), 24'(0), 24'(100), 24'(0), 24'(0)});
		// nearly collinear t shape
		send_pair({-24'(500), 24'(500), 24'(0), 24'(500), 24'(1), 24'(1000), 24'(0), 24'(0)});
		send_pair({24'(PMIN), 24'(PMAX), 24'(PMIN), 24'(PMAX),
			24'(PMAX), 24'(PMIN), 24'(PMAX), 24'(PMIN)});

		write_tolerance('0);
		send_random(200);
		write_tolerance(16'hffff);
		quiet = 1;
		send_random(200);
		quiet = 0;
		write_tolerance(CFG_W'($urandom_range(2, 65534)));
		send_random(50);
		hold_req = 1;
		send_random(150);
		write_tolerance(TOL_RESET);
		send_random(280);
		s_tvalid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("checked %0d results for %0d pairs, %0d of them touching",
			sb.checked, pairs_sent, sb.hits);
		$display("tolerance settings 1, 0, 65535, random; one long output hold-off");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial idle_cycles = 0;
	initial pairs_sent = 0;
endmodule
